[sv/dcf_pkg.sv]
// Shared types and codes for the door control state machine.
`default_nettype none
package dcf_pkg;

  localparam int DOOR_COUNT_DEF = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DOORS_DISABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOTOR_TIMEOUT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REV_TIMEOUT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_TIMEOUT   = 2'd3;

  localparam logic [15:0] MOTOR_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] REV_TIMEOUT_RST   = 16'd2000;
  localparam logic [15:0] LOCK_TIMEOUT_RST  = 16'd500;

  localparam logic [3:0] DS_IDLE     = 4'd0;
  localparam logic [3:0] DS_OPENING  = 4'd1;
  localparam logic [3:0] DS_OPEN     = 4'd2;
  localparam logic [3:0] DS_CLOSING  = 4'd3;
  localparam logic [3:0] DS_REVERSAL = 4'd4;
  localparam logic [3:0] DS_CLOSED   = 4'd5;
  localparam logic [3:0] DS_LOCKING  = 4'd6;
  localparam logic [3:0] DS_LOCKED   = 4'd7;
  localparam logic [3:0] DS_FAULT    = 4'd8;

  localparam logic [1:0] MOT_NONE  = 2'd0;
  localparam logic [1:0] MOT_STOP  = 2'd1;
  localparam logic [1:0] MOT_OPEN  = 2'd2;
  localparam logic [1:0] MOT_CLOSE = 2'd3;

  localparam logic [1:0] LCK_NONE      = 2'd0;
  localparam logic [1:0] LCK_ENGAGE    = 2'd1;
  localparam logic [1:0] LCK_DISENGAGE = 2'd2;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_DISAGREE = 2'd1;
  localparam logic [1:0] EV_FAULT    = 2'd2;

  // one poll as latched at transfer
  typedef struct packed {
    logic [7:0]  door_index;
    logic        open_request;
    logic        close_request;
    logic [3:0]  position_sensors;
    logic [1:0]  lock_sensors;
    logic        obstacle_seen;
    logic        speed_lockout;
    logic        safe_state;
    logic [31:0] now_ms;
    logic        lock_driver_ok;
  } poll_t;

  // per-door stored entry
  typedef struct packed {
    logic [3:0]  state;
    logic [31:0] entry_ms;
  } door_entry_t;

  typedef struct packed {
    logic [7:0]  doors_disabled;
    logic [15:0] motor_timeout_ms;
    logic [15:0] reversal_timeout_ms;
    logic [15:0] lock_timeout_ms;
  } dcf_cfg_t;

  typedef struct packed {
    logic [3:0] new_state;
    logic [1:0] motor;
    logic [1:0] lock;
    logic [1:0] ev;
  } step_res_t;

endpackage
`default_nettype wire

[sv/door_control_fsm_unit.sv]
// Door control state machine: per-door state and entry time held in a RAM.
//
// Each transfer on the input channel is one poll of one door. The door's state
// and state-entry time sit in one synchronous RAM; the poll's transfer cycle
// issues the read, and the following cycle runs the transition. The entry is
// written back and the output register loaded as soon as the output register
// is free; the next poll is taken the cycle after the write-back, so a poll of
// the same door always sees the updated entry. A finished result waits in the
// output register; a new poll may be taken meanwhile, and its write-back waits
// while the output register is still full and stalled. Reset marks every door
// idle with entry time zero at once through per-door valid bits; there is no
// clearing pass. Out-of-range door indexes touch nothing and report range_error.
`default_nettype none
module door_control_fsm_unit #(
  parameter int DOOR_COUNT = dcf_pkg::DOOR_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic [dcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dcf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    door_index,
  input  wire logic                          open_request,
  input  wire logic                          close_request,
  input  wire logic [3:0]                    position_sensors,
  input  wire logic [1:0]                    lock_sensors,
  input  wire logic                          obstacle_seen,
  input  wire logic                          speed_lockout,
  input  wire logic                          safe_state,
  input  wire logic [31:0]                   now_ms,
  input  wire logic                          lock_driver_ok,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [3:0]                         door_state,
  output logic [1:0]                         motor_action,
  output logic [1:0]                         lock_action,
  output logic [1:0]                         event_code,
  output logic                               range_error
);
  import dcf_pkg::*;

  localparam int IDX_W = (DOOR_COUNT > 1) ? $clog2(DOOR_COUNT) : 1;
  localparam int ENTRY_W = $bits(door_entry_t);
  localparam logic [8:0] DOOR_LIMIT = 9'(DOOR_COUNT);

  typedef enum logic [1:0] {
    CTL_IDLE = 2'b01,
    CTL_EXEC = 2'b10
  } ctl_state_t;

  ctl_state_t  ctl, ctl_next;
  dcf_cfg_t    cfg;
  poll_t       poll;
  poll_t       poll_in;
  logic        poll_in_range;
  logic        entry_was_valid;
  logic [DOOR_COUNT-1:0] entry_valid;
  door_entry_t rd_entry, cur_entry, wr_entry;
  step_res_t   res;
  logic        accept;
  logic        out_free;
  logic        commit;
  logic        in_range;
  logic        wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;

  assign poll_in = '{door_index: door_index, open_request: open_request,
                     close_request: close_request, position_sensors: position_sensors,
                     lock_sensors: lock_sensors, obstacle_seen: obstacle_seen,
                     speed_lockout: speed_lockout, safe_state: safe_state,
                     now_ms: now_ms, lock_driver_ok: lock_driver_ok};

  assign in_range = {1'b0, door_index} < DOOR_LIMIT;
  assign in_stall = (ctl != CTL_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign commit   = (ctl == CTL_EXEC) && out_free;
  assign rd_addr  = door_index[IDX_W-1:0];
  assign wr_addr  = poll.door_index[IDX_W-1:0];
  assign wr_en    = commit && poll_in_range;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.doors_disabled      <= '0;
      cfg.motor_timeout_ms    <= MOTOR_TIMEOUT_RST;
      cfg.reversal_timeout_ms <= REV_TIMEOUT_RST;
      cfg.lock_timeout_ms     <= LOCK_TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DOORS_DISABLED: cfg.doors_disabled      <= cfg_data[7:0];
        REG_MOTOR_TIMEOUT:  cfg.motor_timeout_ms    <= cfg_data;
        REG_REV_TIMEOUT:    cfg.reversal_timeout_ms <= cfg_data;
        REG_LOCK_TIMEOUT:   cfg.lock_timeout_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  dcf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DOOR_COUNT),
    .AW   (IDX_W)
  ) u_state_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_entry),
    .rd_en  (accept && in_range),
    .rd_addr(rd_addr),
    .rd_data(rd_entry)
  );

  // never-written entries read as idle, time zero
  assign cur_entry = entry_was_valid ? rd_entry
                                     : door_entry_t'{state: DS_IDLE, entry_ms: '0};

  dcf_step u_step (
    .poll (poll),
    .entry(cur_entry),
    .cfg  (cfg),
    .res  (res)
  );

  assign wr_entry.state    = res.new_state;
  assign wr_entry.entry_ms = (res.new_state != cur_entry.state) ? poll.now_ms
                                                                 : cur_entry.entry_ms;

  always_comb begin
    ctl_next = ctl;
    unique case (ctl)
      CTL_IDLE: if (accept) ctl_next = CTL_EXEC;
      CTL_EXEC: if (out_free) ctl_next = CTL_IDLE;
      default:  ctl_next = CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl         <= CTL_IDLE;
      entry_valid <= '0;
      out_valid   <= 1'b0;
    end else begin
      ctl <= ctl_next;
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // poll latch and valid-bit snapshot at transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      poll            <= poll_in;
      poll_in_range   <= in_range;
      entry_was_valid <= in_range && entry_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      range_error <= !poll_in_range;
      if (poll_in_range) begin
        door_state   <= res.new_state;
        motor_action <= res.motor;
        lock_action  <= res.lock;
        event_code   <= res.ev;
      end else begin
        door_state   <= DS_IDLE;
        motor_action <= MOT_NONE;
        lock_action  <= LCK_NONE;
        event_code   <= EV_NONE;
      end
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (ctl == CTL_EXEC))
    else $error("poll transfer did not start an update");

  a_write_only_in_exec: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (ctl == CTL_EXEC) && poll_in_range)
    else $error("state RAM written outside an update");

  a_range_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && range_error) |-> (door_state == DS_IDLE) && (motor_action == MOT_NONE)
      && (lock_action == LCK_NONE) && (event_code == EV_NONE))
    else $error("range error result carries nonzero fields");

  a_result_follows_commit: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid && (ctl == CTL_IDLE))
    else $error("update finished without a result");

endmodule
`default_nettype wire

[sv/dcf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dcf_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[sv/dcf_step.sv]
// One transition of a door's state machine from the stored entry and a poll.
`default_nettype none
module dcf_step (
  input  wire dcf_pkg::poll_t       poll,
  input  wire dcf_pkg::door_entry_t entry,
  input  wire dcf_pkg::dcf_cfg_t    cfg,
  output dcf_pkg::step_res_t        res
);
  import dcf_pkg::*;

  logic [31:0] elapsed;
  logic        disabled;
  logic        may_open;
  logic        may_close;
  logic        open_agree, open_differ;
  logic        closed_agree, closed_differ;
  logic        lock_agree, lock_differ;
  logic        motor_to, rev_to, lock_to;

  // elapsed wraps modulo 2^32
  assign elapsed  = poll.now_ms - entry.entry_ms;
  assign disabled = (poll.door_index[7:3] == 5'd0) &&
                    cfg.doors_disabled[poll.door_index[2:0]];
  assign may_open  = !poll.safe_state && poll.open_request &&
                     !poll.speed_lockout && !disabled;
  assign may_close = !poll.safe_state && poll.close_request && !disabled;

  assign open_agree    = poll.position_sensors[0] & poll.position_sensors[2];
  assign open_differ   = poll.position_sensors[0] ^ poll.position_sensors[2];
  assign closed_agree  = poll.position_sensors[1] & poll.position_sensors[3];
  assign closed_differ = poll.position_sensors[1] ^ poll.position_sensors[3];
  assign lock_agree    = poll.lock_sensors[0] & poll.lock_sensors[1];
  assign lock_differ   = poll.lock_sensors[0] ^ poll.lock_sensors[1];

  assign motor_to = elapsed >= {16'd0, cfg.motor_timeout_ms};
  assign rev_to   = elapsed >= {16'd0, cfg.reversal_timeout_ms};
  assign lock_to  = elapsed >= {16'd0, cfg.lock_timeout_ms};

  always_comb begin
    res.new_state = entry.state;
    res.motor     = MOT_NONE;
    res.lock      = LCK_NONE;
    res.ev        = EV_NONE;
    unique case (entry.state)
      DS_IDLE: begin
        if (may_open) begin
          res.motor     = MOT_OPEN;
          res.new_state = DS_OPENING;
        end
      end
      DS_OPENING: begin
        priority if (poll.safe_state) begin
          res.motor = MOT_STOP; res.new_state = DS_FAULT;
        end else if (open_differ) begin
          res.ev = EV_DISAGREE; res.motor = MOT_STOP; res.new_state = DS_FAULT;
        end else if (open_agree || poll.obstacle_seen) begin
          // obstacle while opening: treat as fully open
          res.motor = MOT_STOP; res.new_state = DS_OPEN;
        end else if (motor_to) begin
          res.ev = EV_FAULT; res.motor = MOT_STOP; res.new_state = DS_FAULT;
        end else begin
          res.new_state = entry.state;
        end
      end
      DS_OPEN: begin
        if (may_close) begin
          res.motor     = MOT_CLOSE;
          res.new_state = DS_CLOSING;
        end
      end
      DS_CLOSING: begin
        priority if (poll.safe_state) begin
          res.motor = MOT_STOP; res.new_state = DS_FAULT;
        end else if (poll.obstacle_seen) begin
          res.motor = MOT_OPEN; res.ev = EV_DISAGREE; res.new_state = DS_REVERSAL;
        end else if (closed_differ) begin
          res.ev = EV_DISAGREE; res.motor = MOT_STOP; res.new_state = DS_FAULT;
        end else if (closed_agree) begin
          res.motor = MOT_STOP; res.new_state = DS_CLOSED;
        end else if (motor_to) begin
          res.ev = EV_FAULT; res.motor = MOT_STOP; res.new_state = DS_FAULT;
        end else begin
          res.new_state = entry.state;
        end
      end
      DS_REVERSAL: begin
        priority if (open_agree) begin
          res.motor = MOT_STOP; res.new_state = DS_OPEN;
        end else if (rev_to) begin
          res.ev = EV_FAULT; res.motor = MOT_STOP; res.new_state = DS_FAULT;
        end else begin
          res.new_state = entry.state;
        end
      end
      DS_CLOSED: begin
        res.lock = LCK_ENGAGE;
        if (poll.lock_driver_ok) begin
          res.new_state = DS_LOCKING;
        end else begin
          res.ev = EV_FAULT; res.new_state = DS_FAULT;
        end
      end
      DS_LOCKING: begin
        priority if (lock_differ) begin
          res.ev = EV_DISAGREE; res.new_state = DS_FAULT;
        end else if (lock_agree) begin
          res.new_state = DS_LOCKED;
        end else if (lock_to) begin
          res.ev = EV_FAULT; res.new_state = DS_FAULT;
        end else begin
          res.new_state = entry.state;
        end
      end
      DS_LOCKED: begin
        if (may_open) begin
          res.lock = LCK_DISENGAGE;
          if (poll.lock_driver_ok) begin
            res.motor = MOT_OPEN; res.new_state = DS_OPENING;
          end else begin
            res.ev = EV_FAULT; res.new_state = DS_FAULT;
          end
        end
      end
      DS_FAULT: begin
        res.new_state = DS_FAULT;
      end
      default: begin
        // corrupt stored code: stop and latch fault
        res.motor     = MOT_STOP;
        res.new_state = DS_FAULT;
      end
    endcase
  end

endmodule
`default_nettype wire
